// ===== rtl/psg_pkg.sv =====
// Shared types and constants for the PRD scatter-gather builder.
`timescale 1ns / 1ps

package psg_pkg;

    // Default geometry of the descriptor table.
    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int MAX_ENTRIES_DEF = 1024;

    // Entries one segment may produce at most.
    localparam int MAX_RESULTS = 17;
    localparam int K_W         = $clog2(MAX_RESULTS);

    // Field widths.
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 16;
    localparam int CUT_W    = 17;
    localparam int COUNT_W  = 13;
    localparam int INDEX_W  = 10;
    localparam int NIDX_W   = 11;
    localparam int LIMIT_W  = 13;
    localparam int STATUS_W = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ODD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } psg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_needed;
        logic step_final;
        logic out_free;
    } psg_stat_t;

endpackage

// ===== rtl/psg_ctrl.sv =====
// Controller state machine that sequences request intake and entry generation.
`timescale 1ns / 1ps

module psg_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psg_pkg::psg_stat_t  stat,
    output psg_pkg::psg_cmd_t   cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    // Requests are taken only while no segment is being cut.
    assign in_ready = (state_reg == ST_IDLE);

    // Command decode and next state.
    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid && stat.run_needed)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = stat.out_free;
                if (stat.out_free && stat.step_final)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/psg_datapath.sv =====
// Datapath: request state, segment cutter and the registered output stage.
`timescale 1ns / 1ps

module psg_datapath
#(
    parameter int PAGE_BYTES  = psg_pkg::PAGE_BYTES_DEF,
    parameter int MAX_ENTRIES = psg_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  psg_pkg::psg_cmd_t               cmd,
    output psg_pkg::psg_stat_t              stat,
    input  logic                            new_request,
    input  logic [psg_pkg::ADDR_W-1:0]      total_bytes,
    input  logic [psg_pkg::ADDR_W-1:0]      seg_addr,
    input  logic [psg_pkg::LEN_W-1:0]       seg_len,
    input  logic                            last_segment,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [psg_pkg::ADDR_W-1:0]      entry_base,
    output logic [psg_pkg::COUNT_W-1:0]     entry_count,
    output logic [psg_pkg::INDEX_W-1:0]     entry_index,
    output logic                            end_of_table,
    output logic [psg_pkg::STATUS_W-1:0]    status,
    output logic                            last
);

    localparam int PAGE_W = $clog2(PAGE_BYTES);

    // Request state.
    logic [psg_pkg::ADDR_W-1:0]   bytes_rem_reg;
    logic [psg_pkg::NIDX_W-1:0]   next_idx_reg;
    logic                         active_reg;

    // Segment being cut.
    logic [psg_pkg::ADDR_W-1:0]   addr_reg;
    logic [psg_pkg::LEN_W-1:0]    seg_left_reg;
    logic                         last_seg_reg;
    logic [psg_pkg::K_W-1:0]      k_reg;

    // Output stage.
    logic                         out_valid_reg;
    logic [psg_pkg::ADDR_W-1:0]   base_reg;
    logic [psg_pkg::COUNT_W-1:0]  count_reg;
    logic [psg_pkg::INDEX_W-1:0]  index_reg;
    logic                         eot_reg;
    logic [psg_pkg::STATUS_W-1:0] status_reg;
    logic                         last_reg;

    // Intake decode.
    logic                         active_after;

    // Cutter signals.
    logic [psg_pkg::CUT_W-1:0]    n_clamp;
    logic [psg_pkg::CUT_W-1:0]    to_bound;
    logic [psg_pkg::CUT_W-1:0]    n_cut;
    logic                         odd_addr;
    logic                         table_full;
    logic                         cut_err;
    logic [psg_pkg::ADDR_W-1:0]   bytes_new;
    logic [psg_pkg::LEN_W-1:0]    seg_new;
    logic                         bytes_done;
    logic                         cut_final;

    // A loaded segment needs cutting when the request is open and it holds bytes.
    assign active_after    = new_request ? (total_bytes != '0) : active_reg;
    assign stat.run_needed = active_after && (seg_len != '0);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Clamp to the remaining total, then stop at the next page boundary.
    always_comb
    begin
        if ({16'd0, seg_left_reg} < bytes_rem_reg)
        begin
            n_clamp = {1'b0, seg_left_reg};
        end
        else
        begin
            n_clamp = {1'b0, bytes_rem_reg[psg_pkg::LEN_W-1:0]};
        end
        to_bound = psg_pkg::CUT_W'(PAGE_BYTES)
                 - psg_pkg::CUT_W'(addr_reg[PAGE_W-1:0]);
        n_cut    = (n_clamp > to_bound) ? to_bound : n_clamp;
    end

    // Error checks and what this entry leaves behind.
    assign odd_addr   = addr_reg[0];
    assign table_full = {2'd0, next_idx_reg} >= psg_pkg::LIMIT_W'(MAX_ENTRIES);
    assign cut_err    = odd_addr || table_full;
    assign bytes_new  = bytes_rem_reg - psg_pkg::ADDR_W'(n_cut);
    assign seg_new    = seg_left_reg - n_cut[psg_pkg::LEN_W-1:0];
    assign bytes_done = (bytes_new == '0);
    assign cut_final  = cut_err || bytes_done || (seg_new == '0)
                     || (k_reg == psg_pkg::K_W'(psg_pkg::MAX_RESULTS - 1));
    assign stat.step_final = cut_final;

    // Request and segment state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_rem_reg <= '0;
            next_idx_reg  <= '0;
            active_reg    <= 1'b0;
            k_reg         <= '0;
        end
        else if (cmd.load)
        begin
            if (new_request)
            begin
                bytes_rem_reg <= total_bytes;
                next_idx_reg  <= '0;
            end
            // An empty closing segment shuts the request without a result.
            active_reg <= active_after && !((seg_len == '0) && last_segment);
            k_reg      <= '0;
        end
        else if (cmd.step)
        begin
            if (cut_err)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                bytes_rem_reg <= bytes_new;
                next_idx_reg  <= next_idx_reg + 1'b1;
                k_reg         <= k_reg + 1'b1;
                if (bytes_done || (cut_final && last_seg_reg))
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    // Segment payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg     <= seg_addr;
            seg_left_reg <= seg_len;
            last_seg_reg <= last_segment;
        end
        else if (cmd.step)
        begin
            addr_reg     <= addr_reg + psg_pkg::ADDR_W'(n_cut);
            seg_left_reg <= seg_new;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            base_reg <= addr_reg;
            last_reg <= cut_final;
            if (cut_err)
            begin
                count_reg  <= '0;
                index_reg  <= '0;
                eot_reg    <= 1'b0;
                status_reg <= odd_addr ? psg_pkg::ST_ODD : psg_pkg::ST_NO_ROOM;
            end
            else
            begin
                count_reg  <= n_cut[psg_pkg::COUNT_W-1:0];
                index_reg  <= next_idx_reg[psg_pkg::INDEX_W-1:0];
                eot_reg    <= bytes_done || (cut_final && last_seg_reg);
                status_reg <= psg_pkg::ST_OK;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_base   = base_reg;
    assign entry_count  = count_reg;
    assign entry_index  = index_reg;
    assign end_of_table = eot_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    // An error result carries no count, never ends the table and is the last of its segment.
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != psg_pkg::ST_OK))
            |-> ((count_reg == '0) && !eot_reg && last_reg))
        else $error("error result with count or end-of-table set");

    // The entry that ends the table is always the last of its segment.
    a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eot_reg) |-> last_reg)
        else $error("end-of-table on a non-final entry");

    // An error closes the request.
    a_err_close: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cut_err) |=> !active_reg)
        else $error("request still open after an error");

    // Cutting only runs on an open request with bytes in hand.
    a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (active_reg && (bytes_rem_reg != '0) && (seg_left_reg != '0)))
        else $error("entry cut with no open request");

endmodule

// ===== rtl/prd_scatter_gather_builder.sv =====
// Top level of the PRD scatter-gather builder: controller plus datapath.
//
//  Channel   Dir   Handshake                  Payload
//  s_axis    in    s_axis_tvalid/tready       tdata: total_bytes, seg_addr, seg_len;
//                                             tuser: new_request; tlast: last_segment
//  m_axis    out   m_axis_tvalid/tready       tdata: entry_base, entry_count,
//                                             entry_index, end_of_table;
//                                             tuser: status; tlast: last
//
// A request is accepted, then the cutter issues one descriptor entry per cycle while
// m_axis is not stalled (at most 17 entries per segment).
// Entries come from the single entry-cutting step in the datapath.
// rst_n clears the request state and the output valid flag asynchronously.
// A stalled m_axis holds the cutter; one finished entry waits in the output
// register while the next request can already be accepted.
`timescale 1ns / 1ps

module prd_scatter_gather_builder
#(
    parameter int PAGE_BYTES  = psg_pkg::PAGE_BYTES_DEF,
    parameter int MAX_ENTRIES = psg_pkg::MAX_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // total_bytes[31:0], seg_addr[63:32], seg_len[79:64]
    input  logic        s_axis_tuser,   // new_request
    input  logic        s_axis_tlast,   // last_segment
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // entry_base[31:0], entry_count[44:32],
                                        // entry_index[54:45], end_of_table[55]
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast    // last
);

    psg_pkg::psg_cmd_t  cmd;
    psg_pkg::psg_stat_t stat;

    logic [psg_pkg::ADDR_W-1:0]   entry_base;
    logic [psg_pkg::COUNT_W-1:0]  entry_count;
    logic [psg_pkg::INDEX_W-1:0]  entry_index;
    logic                         end_of_table;

    // Sequencer.
    psg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Request state, cutter and output register.
    psg_datapath
    #(
        .PAGE_BYTES  (PAGE_BYTES),
        .MAX_ENTRIES (MAX_ENTRIES)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .new_request  (s_axis_tuser),
        .total_bytes  (s_axis_tdata[31:0]),
        .seg_addr     (s_axis_tdata[63:32]),
        .seg_len      (s_axis_tdata[79:64]),
        .last_segment (s_axis_tlast),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .entry_base   (entry_base),
        .entry_count  (entry_count),
        .entry_index  (entry_index),
        .end_of_table (end_of_table),
        .status       (m_axis_tuser),
        .last         (m_axis_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {end_of_table, entry_index, entry_count, entry_base};

endmodule
